// ----- hdl/vn2d_pkg.sv -----
package vn2d_pkg;

    // Hash multipliers and row scramble constant
    localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;
    localparam logic [31:0] ROW_MUL   = 32'h27d4eb2d;

    // Register stages from input beat to output register
    localparam int NUM_STAGES = 10;

    // Field widths of the stream beats
    localparam int COORD_BITS   = 32;
    localparam int NOISE_BITS   = 16;
    localparam int IN_DATA_BITS = 2 * COORD_BITS;

    typedef logic [31:0] word_t;

    function automatic word_t xor_shift16(input word_t v);
        return v ^ (v >> 16);
    endfunction

    function automatic word_t xor_shift15(input word_t v);
        return v ^ (v >> 15);
    endfunction

endpackage

// ----- hdl/value_noise_2d_unit.sv -----
// Two-dimensional lattice value noise. Each input beat carries a signed
// coordinate pair with FRAC_BITS fraction bits; the floor selects a lattice
// cell whose four corners are hashed to pseudo-random values of OUT_BITS
// bits, and the corners are blended bilinearly with smoothstep-eased
// fractions. Results come out in input order, one per input beat. The block
// is a ten-stage pipeline that takes a new beat every cycle unless all stages
// are full and stalled. A result leaves from the output register, the last
// of the ten stages: the coordinate split, the four multiply stages of the
// row and corner hashes, the final hash shift, and the two blend levels,
// each split into a multiply stage and a sum stage. Stalls on the output side
// squeeze out bubbles first, so input beats are still taken while a finished
// result waits as long as any stage is empty.
module value_noise_2d_unit #(
    parameter int FRAC_BITS = 16,
    parameter int OUT_BITS  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: x_coord [31:0], y_coord [63:32]
    input  logic [vn2d_pkg::IN_DATA_BITS-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: noise_value [15:0]
    output logic [vn2d_pkg::NOISE_BITS-1:0]      m_tdata
);
    import vn2d_pkg::*;

    localparam int F = FRAC_BITS;
    localparam int O = OUT_BITS;
    localparam int PW = O + F + 1;
    localparam logic [F+1:0] THREE_ONE = (F + 2)'(3) << F;
    localparam logic [F:0]   ONE       = (F + 1)'(1) << F;

    // Stage valids and per-stage ready chain
    logic [NUM_STAGES:1]   valid_reg;
    logic [NUM_STAGES+1:1] rdy;

    always_comb begin
        rdy[NUM_STAGES+1] = m_tready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = valid_reg[NUM_STAGES];

    // Advance valid bits wherever the next stage can take a beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[1]) begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: split coordinates into floor cell and fraction
    logic [COORD_BITS-1:0] x_in, y_in;
    word_t                 xc1_reg, yc1_reg;
    logic [F-1:0]          fx1_reg, fy1_reg;

    assign x_in = s_tdata[COORD_BITS-1:0];
    assign y_in = s_tdata[2*COORD_BITS-1:COORD_BITS];

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            xc1_reg <= {{F{x_in[COORD_BITS-1]}}, x_in[COORD_BITS-1:F]};
            yc1_reg <= {{F{y_in[COORD_BITS-1]}}, y_in[COORD_BITS-1:F]};
            fx1_reg <= x_in[F-1:0];
            fy1_reg <= y_in[F-1:0];
        end
    end

    // Stage 2: first row-hash multiply, column scramble, fraction squares
    word_t           hy0_2_reg, hy1_2_reg, px0_2_reg, px1_2_reg;
    logic [F-1:0]    tx2_2_reg, ty2_2_reg, fx2_reg, fy2_reg;
    logic [2*F-1:0]  tx_sq_next, ty_sq_next;
    word_t           hy0_2_next, hy1_2_next, px0_2_next, px1_2_next;

    always_comb begin
        tx_sq_next = (2 * F)'(fx1_reg) * (2 * F)'(fx1_reg);
        ty_sq_next = (2 * F)'(fy1_reg) * (2 * F)'(fy1_reg);
        hy0_2_next = xor_shift16(yc1_reg) * MIX_MUL_A;
        hy1_2_next = xor_shift16(yc1_reg + 32'd1) * MIX_MUL_A;
        px0_2_next = xc1_reg * ROW_MUL;
        px1_2_next = (xc1_reg + 32'd1) * ROW_MUL;
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            hy0_2_reg <= hy0_2_next;
            hy1_2_reg <= hy1_2_next;
            px0_2_reg <= px0_2_next;
            px1_2_reg <= px1_2_next;
            tx2_2_reg <= tx_sq_next[2*F-1:F];
            ty2_2_reg <= ty_sq_next[2*F-1:F];
            fx2_reg   <= fx1_reg;
            fy2_reg   <= fy1_reg;
        end
    end

    // Stage 3: second row-hash multiply, finish smoothstep
    word_t           hy0_3_reg, hy1_3_reg, px0_3_reg, px1_3_reg;
    logic [F-1:0]    sx3_reg, sy3_reg;
    logic [F+1:0]    kx_next, ky_next;
    logic [2*F+1:0]  sx_prod_next, sy_prod_next;

    always_comb begin
        kx_next      = THREE_ONE - {1'b0, fx2_reg, 1'b0};
        ky_next      = THREE_ONE - {1'b0, fy2_reg, 1'b0};
        sx_prod_next = (2 * F + 2)'(tx2_2_reg) * (2 * F + 2)'(kx_next);
        sy_prod_next = (2 * F + 2)'(ty2_2_reg) * (2 * F + 2)'(ky_next);
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            hy0_3_reg <= xor_shift15(hy0_2_reg) * MIX_MUL_B;
            hy1_3_reg <= xor_shift15(hy1_2_reg) * MIX_MUL_B;
            px0_3_reg <= px0_2_reg;
            px1_3_reg <= px1_2_reg;
            sx3_reg   <= sx_prod_next[2*F-1:F];
            sy3_reg   <= sy_prod_next[2*F-1:F];
        end
    end

    // Stage 4: combine rows and columns, first corner-hash multiply
    word_t        g0_next, g1_next;
    word_t        corner_in [4];
    word_t        m1_reg [4];
    logic [F-1:0] sx4_reg, sy4_reg;

    always_comb begin
        g0_next = xor_shift16(hy0_3_reg);
        g1_next = xor_shift16(hy1_3_reg);
        corner_in[0] = px0_3_reg ^ g0_next;
        corner_in[1] = px1_3_reg ^ g0_next;
        corner_in[2] = px0_3_reg ^ g1_next;
        corner_in[3] = px1_3_reg ^ g1_next;
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            for (int j = 0; j < 4; j++) begin
                m1_reg[j] <= xor_shift16(corner_in[j]) * MIX_MUL_A;
            end
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
        end
    end

    // Stage 5: second corner-hash multiply
    word_t        m2_reg [4];
    logic [F-1:0] sx5_reg, sy5_reg;

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            for (int j = 0; j < 4; j++) begin
                m2_reg[j] <= xor_shift15(m1_reg[j]) * MIX_MUL_B;
            end
            sx5_reg <= sx4_reg;
            sy5_reg <= sy4_reg;
        end
    end

    // Stage 6: final shift, keep top OUT_BITS of each corner hash
    word_t        h_final [4];
    logic [O-1:0] cor6_reg [4];
    logic [F-1:0] sx6_reg, sy6_reg;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            h_final[j] = xor_shift16(m2_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            for (int j = 0; j < 4; j++) begin
                cor6_reg[j] <= h_final[j][31:32-O];
            end
            sx6_reg <= sx5_reg;
            sy6_reg <= sy5_reg;
        end
    end

    // Stage 7: horizontal blend products
    logic [F:0]    sx_w, sx_inv;
    logic [PW-1:0] prd7_reg [4];
    logic [F-1:0]  sy7_reg;

    assign sx_w   = {1'b0, sx6_reg};
    assign sx_inv = ONE - sx_w;

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            prd7_reg[0] <= PW'(cor6_reg[0]) * PW'(sx_inv);
            prd7_reg[1] <= PW'(cor6_reg[1]) * PW'(sx_w);
            prd7_reg[2] <= PW'(cor6_reg[2]) * PW'(sx_inv);
            prd7_reg[3] <= PW'(cor6_reg[3]) * PW'(sx_w);
            sy7_reg     <= sy6_reg;
        end
    end

    // Stage 8: horizontal blend sums, truncate
    logic [PW:0]   top_sum_next, bot_sum_next;
    logic [O-1:0]  top8_reg, bot8_reg;
    logic [F-1:0]  sy8_reg;

    always_comb begin
        top_sum_next = {1'b0, prd7_reg[0]} + {1'b0, prd7_reg[1]};
        bot_sum_next = {1'b0, prd7_reg[2]} + {1'b0, prd7_reg[3]};
    end

    always_ff @(posedge aclk) begin
        if (rdy[8]) begin
            top8_reg <= top_sum_next[O+F-1:F];
            bot8_reg <= bot_sum_next[O+F-1:F];
            sy8_reg  <= sy7_reg;
        end
    end

    // Stage 9: vertical blend products
    logic [F:0]    sy_w, sy_inv;
    logic [PW-1:0] py0_9_reg, py1_9_reg;

    assign sy_w   = {1'b0, sy8_reg};
    assign sy_inv = ONE - sy_w;

    always_ff @(posedge aclk) begin
        if (rdy[9]) begin
            py0_9_reg <= PW'(top8_reg) * PW'(sy_inv);
            py1_9_reg <= PW'(bot8_reg) * PW'(sy_w);
        end
    end

    // Stage 10: vertical blend sum into the output register
    logic [PW:0]           res_sum_next;
    logic [O-1:0]          res10_reg;
    logic [O+NOISE_BITS-1:0] res_ext;

    assign res_sum_next = {1'b0, py0_9_reg} + {1'b0, py1_9_reg};

    always_ff @(posedge aclk) begin
        if (rdy[10]) begin
            res10_reg <= res_sum_next[O+F-1:F];
        end
    end

    // Carry the low bits of the result on the beat
    assign res_ext = {{NOISE_BITS{1'b0}}, res10_reg};
    assign m_tdata = res_ext[NOISE_BITS-1:0];

endmodule
